[design/sag_pkg.sv]
// ----------------------------------------------------------------------------
// sag_pkg
// Shared types and constants for the sample average gamma to RGB8 unit.
// ----------------------------------------------------------------------------
`default_nettype none

package sag_pkg;

	// Channel sum width; the sum is Q16.16, so the upper half is the integer part
	localparam int SUM_W      = 32;
	localparam int HALF_W     = SUM_W / 2;
	localparam int IDX_W      = 24;
	localparam int CNT_W      = 16;
	localparam int BYTE_W     = 8;

	// Division: HALF_W quotient bits, spread over DIV_STAGES stages
	localparam int DIV_STAGES = 4;
	localparam int DIV_STEPS  = HALF_W / DIV_STAGES;

	// Square root: BYTE_W result bits over two stages
	localparam int SQ_STEPS   = BYTE_W / 2;

	// Input register, division stages, two root stages
	localparam int NUM_STAGES = 1 + DIV_STAGES + 2;

	// 255 squared: any average at or above this maps to full scale
	localparam logic [HALF_W-1:0] SAT_LIMIT = HALF_W'(65025);
	localparam logic [BYTE_W-1:0] BYTE_MAX  = 8'hFF;

	// Register index, taken from paddr[2]
	typedef enum logic {
		REG_SAMPLE_COUNT = 1'b0,
		REG_PREVIEW_MODE = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [IDX_W-1:0] pixel_index;
		logic [SUM_W-1:0] red_sum;
		logic [SUM_W-1:0] green_sum;
		logic [SUM_W-1:0] blue_sum;
	} in_word_t;

	typedef struct packed {
		logic [IDX_W-1:0]  pixel_position;
		logic [BYTE_W-1:0] red_byte;
		logic [BYTE_W-1:0] green_byte;
		logic [BYTE_W-1:0] blue_byte;
		logic [BYTE_W-1:0] alpha_byte;
	} out_word_t;

endpackage

`default_nettype wire

[design/sample_average_gamma_to_rgb8_unit.sv]
// ----------------------------------------------------------------------------
// sample_average_gamma_to_rgb8_unit
// Averages accumulated Q16.16 RGB sums, applies gamma 2 and packs RGBA8.
// ----------------------------------------------------------------------------
// Usage:
//   Input words (pixel index plus three channel sums) enter on in_valid /
//   in_ready; one RGBA8 word per input leaves on out_valid / out_ready with
//   the pixel index passed through. Alpha is always 255.
//   Each channel is floor(sqrt(sum / sample_count)) in integer units,
//   saturated at 255; preview mode or a zero count divides by one.
//   The pipeline is an input register, four division stages of four
//   quotient bits each, and two root stages of four bits each.
//   Throughput is one word per cycle while out_ready stays high.
//   When the receiver stalls, the whole pipeline holds; in_ready falls
//   only while the output word waits and is not taken.
//   Reset clears all valid bits and loads sample_count = 1, preview = 0.
//   The APB port writes registers at 0x0 (sample_count) and 0x4
//   (preview_mode); write them only while the pipeline is empty.
// ----------------------------------------------------------------------------
`default_nettype none

module sample_average_gamma_to_rgb8_unit
	import sag_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire in_word_t  in_data,
	output logic           out_valid,
	input  wire logic      out_ready,
	output out_word_t      out_data,
	input  wire logic      psel,
	input  wire logic      penable,
	input  wire logic      pwrite,
	input  wire logic [2:0] paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]    prdata,
	output logic           pready
);

	logic [CNT_W-1:0]      sample_count_q;
	logic                  preview_mode_q;
	logic [CNT_W-1:0]      dv;
	logic                  adv;
	logic [NUM_STAGES-1:0] vld_s;
	logic [IDX_W-1:0]      idx_s [NUM_STAGES];
	logic [BYTE_W-1:0]     red_b;
	logic [BYTE_W-1:0]     green_b;
	logic [BYTE_W-1:0]     blue_b;
	reg_idx_t              reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = reg_idx_t'(paddr[2]);

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_count_q <= CNT_W'(1);
			preview_mode_q <= 1'b0;
		end else if (psel && penable && pwrite) begin
			unique case (reg_sel)
				REG_SAMPLE_COUNT: sample_count_q <= pwdata[CNT_W-1:0];
				REG_PREVIEW_MODE: preview_mode_q <= pwdata[0];
				default:          ;
			endcase
		end
	end

	// Read back
	always_comb begin
		unique case (reg_sel)
			REG_SAMPLE_COUNT: prdata = 32'(sample_count_q);
			REG_PREVIEW_MODE: prdata = 32'(preview_mode_q);
			default:          prdata = '0;
		endcase
	end

	// Divisor: one in preview or for a zero count
	assign dv = (preview_mode_q || (sample_count_q == '0)) ? CNT_W'(1) : sample_count_q;

	// Hold everything while the output word waits
	assign adv      = !vld_s[NUM_STAGES-1] || out_ready;
	assign in_ready = adv;

	// Valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[NUM_STAGES-2:0], in_valid};
		end
	end

	// Pixel index shift line
	always_ff @(posedge clk) begin
		if (adv) begin
			idx_s[0] <= in_data.pixel_index;
			for (int k = 1; k < NUM_STAGES; k++) begin
				idx_s[k] <= idx_s[k-1];
			end
		end
	end

	sag_chan u_red (
		.clk      (clk),
		.en       (adv),
		.sum      (in_data.red_sum),
		.dv       (dv),
		.byte_val (red_b)
	);

	sag_chan u_green (
		.clk      (clk),
		.en       (adv),
		.sum      (in_data.green_sum),
		.dv       (dv),
		.byte_val (green_b)
	);

	sag_chan u_blue (
		.clk      (clk),
		.en       (adv),
		.sum      (in_data.blue_sum),
		.dv       (dv),
		.byte_val (blue_b)
	);

	// Pack the output word
	assign out_valid               = vld_s[NUM_STAGES-1];
	assign out_data.pixel_position = idx_s[NUM_STAGES-1];
	assign out_data.red_byte       = red_b;
	assign out_data.green_byte     = green_b;
	assign out_data.blue_byte      = blue_b;
	assign out_data.alpha_byte     = BYTE_MAX;

endmodule

`default_nettype wire

[design/sag_chan.sv]
// ----------------------------------------------------------------------------
// sag_chan
// One color channel: pipelined restoring division of the sum by the sample
// count, then a pipelined integer square root with saturation at 255.
// ----------------------------------------------------------------------------
`default_nettype none

module sag_chan
	import sag_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              en,
	input  wire logic [SUM_W-1:0]  sum,
	input  wire logic [CNT_W-1:0]  dv,
	output logic      [BYTE_W-1:0] byte_val
);

	logic [SUM_W-1:0]  sum_s1;

	// Division stage registers
	logic [HALF_W-1:0] rem_s   [DIV_STAGES];
	logic [HALF_W-1:0] low_s   [DIV_STAGES];
	logic [HALF_W-1:0] quo_s   [DIV_STAGES];
	logic              dsat_s  [DIV_STAGES];

	logic [HALF_W-1:0] rem_n   [DIV_STAGES];
	logic [HALF_W-1:0] low_n   [DIV_STAGES];
	logic [HALF_W-1:0] quo_n   [DIV_STAGES];
	logic              dsat_n  [DIV_STAGES];

	logic [HALF_W-1:0] dr;
	logic [HALF_W-1:0] dl;
	logic [HALF_W-1:0] dq;
	logic [HALF_W:0]   dt;

	// Root stage registers
	logic [HALF_W-1:0] rad_s6;
	logic [BYTE_W-1:0] root_s6;
	logic              sat_s6;
	logic [BYTE_W-1:0] byte_s7;

	logic [BYTE_W-1:0] root_a;
	logic [BYTE_W-1:0] root_b;
	logic [BYTE_W-1:0] ta;
	logic [BYTE_W-1:0] tb;
	logic              sat_a;

	// Restoring division, DIV_STEPS quotient bits per stage
	always_comb begin
		dr = '0;
		dl = '0;
		dq = '0;
		dt = '0;
		for (int k = 0; k < DIV_STAGES; k++) begin
			if (k == 0) begin
				dr = sum_s1[SUM_W-1:HALF_W];
				dl = sum_s1[HALF_W-1:0];
				dq = '0;
				dsat_n[k] = (sum_s1[SUM_W-1:HALF_W] >= dv);
			end else begin
				dr = rem_s[k-1];
				dl = low_s[k-1];
				dq = quo_s[k-1];
				dsat_n[k] = dsat_s[k-1];
			end
			for (int j = 0; j < DIV_STEPS; j++) begin
				dt = {dr, dl[HALF_W-1]};
				dl = {dl[HALF_W-2:0], 1'b0};
				if (dt >= {1'b0, dv}) begin
					dr = HALF_W'(dt - {1'b0, dv});
					dq = {dq[HALF_W-2:0], 1'b1};
				end else begin
					dr = dt[HALF_W-1:0];
					dq = {dq[HALF_W-2:0], 1'b0};
				end
			end
			rem_n[k] = dr;
			low_n[k] = dl;
			quo_n[k] = dq;
		end
	end

	// Upper root bits, flag full scale
	always_comb begin
		root_a = '0;
		ta     = '0;
		sat_a  = dsat_s[DIV_STAGES-1] || (quo_s[DIV_STAGES-1] >= SAT_LIMIT);
		for (int j = 0; j < SQ_STEPS; j++) begin
			ta = root_a | (8'd1 << (BYTE_W - 1 - j));
			if ((HALF_W'(ta) * HALF_W'(ta)) <= quo_s[DIV_STAGES-1]) begin
				root_a = ta;
			end
		end
	end

	// Lower root bits
	always_comb begin
		root_b = root_s6;
		tb     = '0;
		for (int j = 0; j < SQ_STEPS; j++) begin
			tb = root_b | (8'd1 << (SQ_STEPS - 1 - j));
			if ((HALF_W'(tb) * HALF_W'(tb)) <= rad_s6) begin
				root_b = tb;
			end
		end
	end

	// Advance all stages together
	always_ff @(posedge clk) begin
		if (en) begin
			sum_s1 <= sum;
			for (int k = 0; k < DIV_STAGES; k++) begin
				rem_s[k]  <= rem_n[k];
				low_s[k]  <= low_n[k];
				quo_s[k]  <= quo_n[k];
				dsat_s[k] <= dsat_n[k];
			end
			rad_s6  <= quo_s[DIV_STAGES-1];
			root_s6 <= root_a;
			sat_s6  <= sat_a;
			byte_s7 <= sat_s6 ? BYTE_MAX : root_b;
		end
	end

	assign byte_val = byte_s7;

endmodule

`default_nettype wire
